@@ hdl/sorted_key_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_key_table_core_defines.svh
// Assertion macros for the sorted key table. They expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset
`define SKT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("skt assertion failed");

// Condition in one cycle implies a condition in the next
`define SKT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("skt assertion failed");

`else

`define SKT_ASSERT(label, clk, rst_n, prop)
`define SKT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ hdl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 64;
    localparam int REQ_W = 3;
    localparam int ENT_W = 5;

    typedef logic [REQ_W-1:0] req_t;

    // Request codes
    localparam req_t REQ_INSERT = 3'd0;
    localparam req_t REQ_REMOVE = 3'd1;
    localparam req_t REQ_LOOKUP = 3'd2;
    localparam req_t REQ_ABSENT = 3'd3;
    localparam req_t REQ_DUMP   = 3'd4;

    // Operation that every cell performs at a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    // One table slot
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // Broadcast from control to every cell
    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } bcast_t;

    // Status seen by the controller
    typedef struct packed {
        logic in_fire;
        req_t in_req;
        req_t exec_req;
        logic full;
        logic empty;
        logic found;
        logic slot_free;
        logic dump_end;
    } status_t;

    // Commands from the controller
    typedef struct packed {
        logic     in_ready;
        cell_op_t cell_op;
        logic     out_load;
        logic     is_dump;
        logic     dump_step;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/skt_if.sv @@
// ----------------------------------------------------------------------------
// skt_if
// Valid/ready channels for requests and results of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_req_if;
    logic                             valid;
    logic                             ready;
    logic [skt_pkg::REQ_W-1:0]        req_type;
    logic signed [skt_pkg::KEY_W-1:0] key;
    logic [skt_pkg::PAY_W-1:0]        payload;

    modport source (output valid, req_type, key, payload, input ready);
    modport sink   (input valid, req_type, key, payload, output ready);
endinterface

interface skt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic signed [skt_pkg::KEY_W-1:0] out_key;
    logic [skt_pkg::PAY_W-1:0]        out_payload;
    logic [skt_pkg::ENT_W-1:0]        entries;
    logic                             last;

    modport source (output valid, ok, out_key, out_payload, entries, last, input ready);
    modport sink   (input valid, ok, out_key, out_payload, entries, last, output ready);
endinterface

`default_nettype wire

@@ hdl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the table: compares its key with the broadcast key and takes
// its next contents from itself, a neighbor, the head or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire skt_pkg::bcast_t bcast,
    input  wire skt_pkg::entry_t left,
    input  wire logic            left_lt,
    input  wire skt_pkg::entry_t right,
    input  wire skt_pkg::entry_t head,
    output skt_pkg::entry_t      ent,
    output logic                 lt,
    output logic                 eq
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [skt_pkg::KEY_W-1:0] key_reg;
    logic [skt_pkg::KEY_W-1:0] key_next;
    logic [skt_pkg::PAY_W-1:0] pay_reg;
    logic [skt_pkg::PAY_W-1:0] pay_next;

    assign ent = '{valid: valid_reg, key: key_reg, payload: pay_reg};

    // Signed compare against the request key
    assign lt = valid_reg && ($signed(key_reg) < $signed(bcast.key));
    assign eq = valid_reg && (key_reg == bcast.key);

    // Next contents
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        unique case (bcast.op)
            skt_pkg::CELL_HOLD:
            begin
            end
            skt_pkg::CELL_INSERT:
            begin
                // slots at and after the insert point move one to the right
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next = 1'b1;
                        key_next   = bcast.key;
                        pay_next   = bcast.payload;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        key_next   = left.key;
                        pay_next   = left.payload;
                    end
                end
            end
            skt_pkg::CELL_REMOVE:
            begin
                // slots from the first match on take their right neighbor
                if (!lt)
                begin
                    valid_next = right.valid;
                    key_next   = right.key;
                    pay_next   = right.payload;
                end
            end
            skt_pkg::CELL_ROTATE:
            begin
                // held entries rotate left, the head wraps to the last held slot
                if (valid_reg)
                begin
                    if (right.valid)
                    begin
                        key_next = right.key;
                        pay_next = right.payload;
                    end
                    else
                    begin
                        key_next = head.key;
                        pay_next = head.payload;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot contents
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

endmodule

`default_nettype wire

@@ hdl/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl
// Request sequencer: accepts a beat, runs one update step or streams a
// dump, and paces both against the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire skt_pkg::status_t status,
    output skt_pkg::cmd_t         cmd
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (status.in_fire)
                begin
                    if ((status.in_req == skt_pkg::REQ_DUMP) && !status.empty)
                    begin
                        state_next = skt_pkg::ST_DUMP;
                    end
                    else
                    begin
                        state_next = skt_pkg::ST_EXEC;
                    end
                end
            end
            skt_pkg::ST_EXEC:
            begin
                if (status.slot_free)
                begin
                    state_next = skt_pkg::ST_IDLE;
                end
            end
            skt_pkg::ST_DUMP:
            begin
                if (status.slot_free && status.dump_end)
                begin
                    state_next = skt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.in_ready  = 1'b0;
        cmd.cell_op   = skt_pkg::CELL_HOLD;
        cmd.out_load  = 1'b0;
        cmd.is_dump   = 1'b0;
        cmd.dump_step = 1'b0;
        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            skt_pkg::ST_EXEC:
            begin
                if (status.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    if ((status.exec_req == skt_pkg::REQ_INSERT) && !status.full)
                    begin
                        cmd.cell_op = skt_pkg::CELL_INSERT;
                    end
                    else if ((status.exec_req == skt_pkg::REQ_REMOVE) && status.found)
                    begin
                        cmd.cell_op = skt_pkg::CELL_REMOVE;
                    end
                end
            end
            skt_pkg::ST_DUMP:
            begin
                cmd.is_dump = 1'b1;
                if (status.slot_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.dump_step = 1'b1;
                    cmd.cell_op   = skt_pkg::CELL_ROTATE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sorted_key_table_core.sv @@
// Flow: a request beat is captured in the request registers, then the update
// state loads the result register once it is free; no new request is taken
// until then. A dump streams one entry per cycle while the result register is
// free, rotating the cell chain past the head cell, and leaves the order unchanged.
// Reset: asynchronous, active low; empties the table at once, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Sorted key/payload table built as a chain of shift cells with a result
// register on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_core_defines.svh"

module sorted_key_table_core #(
    parameter int CAPACITY = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    skt_pkg::status_t status;
    skt_pkg::cmd_t    cmd;
    skt_pkg::bcast_t  bcast;

    // Captured request
    skt_pkg::req_t             req_type_reg;
    logic [skt_pkg::KEY_W-1:0] req_key_reg;
    logic [skt_pkg::PAY_W-1:0] req_pay_reg;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] dump_cnt_reg;

    // Cell chain
    skt_pkg::entry_t       cell_ent [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   cell_first;
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   sorted_vec;

    logic                      found;
    logic [skt_pkg::PAY_W-1:0] sel_pay;
    logic                      full;
    logic                      in_fire;

    // Result register
    logic                      rsp_valid_reg;
    logic                      ok_reg;
    logic                      ok_next;
    logic [skt_pkg::KEY_W-1:0] key_reg;
    logic [skt_pkg::KEY_W-1:0] key_next;
    logic [skt_pkg::PAY_W-1:0] pay_reg;
    logic [skt_pkg::PAY_W-1:0] pay_next;
    logic [skt_pkg::ENT_W-1:0] ent_reg;
    logic [skt_pkg::ENT_W-1:0] ent_next;
    logic                      last_reg;
    logic                      last_next;

    assign in_fire = req.valid && req.ready;
    assign full    = (fill_reg == CNT_W'(CAPACITY));

    assign bcast = '{op: cmd.cell_op, key: req_key_reg, payload: req_pay_reg};

    // Chain of cells; the first slot sees an always-less left boundary
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skt_pkg::entry_t left_ent;
        skt_pkg::entry_t right_ent;
        logic            left_lt;

        if (i == 0)
        begin : g_first
            assign left_ent      = '{valid: 1'b1, key: '0, payload: '0};
            assign left_lt       = 1'b1;
            assign sorted_vec[i] = 1'b1;
        end
        else
        begin : g_rest
            assign left_ent      = cell_ent[i-1];
            assign left_lt       = cell_lt[i-1];
            assign sorted_vec[i] = !cell_ent[i].valid ||
                                   ($signed(cell_ent[i-1].key) <= $signed(cell_ent[i].key));
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_ent = '0;
        end
        else
        begin : g_inner
            assign right_ent = cell_ent[i+1];
        end

        skt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bcast   (bcast),
            .left    (left_ent),
            .left_lt (left_lt),
            .right   (right_ent),
            .head    (cell_ent[0]),
            .ent     (cell_ent[i]),
            .lt      (cell_lt[i]),
            .eq      (cell_eq[i])
        );

        // equal keys sit together, so the first match has a smaller key on its left
        assign cell_first[i] = cell_eq[i] && left_lt;
        assign valid_vec[i]  = cell_ent[i].valid;
    end

    // Found flag and payload of the first match
    always_comb
    begin
        sel_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_pay = sel_pay | (cell_first[i] ? cell_ent[i].payload : '0);
        end
    end
    assign found = |cell_eq;

    // Controller
    assign status = '{
        in_fire:   in_fire,
        in_req:    req.req_type,
        exec_req:  req_type_reg,
        full:      full,
        empty:     (fill_reg == '0),
        found:     found,
        slot_free: (!rsp_valid_reg || rsp.ready),
        dump_end:  (CNT_W'(dump_cnt_reg + 1'b1) == fill_reg)
    };

    skt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    assign req.ready = cmd.in_ready;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_type_reg <= req.req_type;
            req_key_reg  <= req.key;
            req_pay_reg  <= req.payload;
        end
    end

    // Fill count and dump position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            dump_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.cell_op == skt_pkg::CELL_INSERT)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (cmd.cell_op == skt_pkg::CELL_REMOVE)
            begin
                fill_reg <= fill_reg - 1'b1;
            end

            if (in_fire)
            begin
                dump_cnt_reg <= '0;
            end
            else if (cmd.dump_step)
            begin
                dump_cnt_reg <= dump_cnt_reg + 1'b1;
            end
        end
    end

    // Result beat contents
    always_comb
    begin
        ok_next   = 1'b0;
        key_next  = req_key_reg;
        pay_next  = '0;
        ent_next  = skt_pkg::ENT_W'(fill_reg);
        last_next = 1'b1;
        if (cmd.is_dump)
        begin
            ok_next   = 1'b1;
            key_next  = cell_ent[0].key;
            pay_next  = cell_ent[0].payload;
            last_next = status.dump_end;
        end
        else
        begin
            unique case (req_type_reg)
                skt_pkg::REQ_INSERT:
                begin
                    ok_next  = !full;
                    pay_next = req_pay_reg;
                    if (!full)
                    begin
                        ent_next = skt_pkg::ENT_W'(fill_reg + 1'b1);
                    end
                end
                skt_pkg::REQ_REMOVE:
                begin
                    ok_next  = found;
                    pay_next = sel_pay;
                    if (found)
                    begin
                        ent_next = skt_pkg::ENT_W'(fill_reg - 1'b1);
                    end
                end
                skt_pkg::REQ_LOOKUP:
                begin
                    ok_next  = found;
                    pay_next = sel_pay;
                end
                skt_pkg::REQ_ABSENT:
                begin
                    ok_next = !found;
                end
                default:
                begin
                    // empty dump and unused codes
                    key_next = '0;
                end
            endcase
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result register data
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ok_reg   <= ok_next;
            key_reg  <= key_next;
            pay_reg  <= pay_next;
            ent_reg  <= ent_next;
            last_reg <= last_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.out_key     = key_reg;
    assign rsp.out_payload = pay_reg;
    assign rsp.entries     = ent_reg;
    assign rsp.last        = last_reg;

    // Checks on the table state; a dump rotates the chain, so order is only
    // checked outside a dump
    `SKT_ASSERT(a_fill_matches_valid, clk, rst_n, $countones(valid_vec) == fill_reg)
    `SKT_ASSERT(a_valid_prefix, clk, rst_n, ((valid_vec + 1'b1) & valid_vec) == '0)
    `SKT_ASSERT(a_keys_sorted, clk, rst_n, cmd.is_dump || (&sorted_vec))
    `SKT_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.cell_op == skt_pkg::CELL_INSERT, fill_reg == $past(fill_reg) + 1'b1)
    `SKT_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, cmd.cell_op == skt_pkg::CELL_REMOVE, fill_reg == $past(fill_reg) - 1'b1)

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table. A short table of directed
// requests (empty table, key extremes, duplicates, full table, unused codes)
// is followed by random request streams that fill and drain the table. A
// mirror of the table predicts every result beat, and a monitor compares each
// accepted beat field by field. Both channels idle in random bursts, and the
// receiver once stalls long enough to back the request channel up.
// ----------------------------------------------------------------------------
module tb_top;

    typedef skt_pkg::req_t req_t;

    localparam int KEY_W = skt_pkg::KEY_W;
    localparam int PAY_W = skt_pkg::PAY_W;
    localparam int ENT_W = skt_pkg::ENT_W;

    localparam req_t REQ_INSERT = skt_pkg::REQ_INSERT;
    localparam req_t REQ_REMOVE = skt_pkg::REQ_REMOVE;
    localparam req_t REQ_LOOKUP = skt_pkg::REQ_LOOKUP;
    localparam req_t REQ_ABSENT = skt_pkg::REQ_ABSENT;
    localparam req_t REQ_DUMP   = skt_pkg::REQ_DUMP;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int LONG_HOLD    = 80;

    // Codes the block does not define; it answers them with an empty result
    localparam req_t REQ_UNUSED_LO = 3'd5;
    localparam req_t REQ_UNUSED_HI = 3'd7;

    localparam logic [PAY_W-1:0] PAY_ONES = '1;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [ENT_W-1:0] entries;
        logic             last;
    } table_result_t;

    typedef struct packed {
        req_t             rq;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             typed;
        table_result_t    want;
    } stim_row_t;

    // Directed requests; rows with typed set carry their own expected beat
    localparam stim_row_t DIR_ROWS [26] = '{
        '{REQ_DUMP,   32'd0, 64'd0, 1'b1, '{1'b0, 32'd0, 64'd0, 5'd0, 1'b1}},
        '{REQ_ABSENT, 32'd5, 64'd0, 1'b1, '{1'b1, 32'd5, 64'd0, 5'd0, 1'b1}},
        '{REQ_REMOVE, 32'd5, 64'd0, 1'b1, '{1'b0, 32'd5, 64'd0, 5'd0, 1'b1}},
        '{REQ_INSERT, 32'h7FFF_FFFF, PAY_ONES, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, PAY_ONES, 5'd1, 1'b1}},
        '{REQ_INSERT, 32'h8000_0000, 64'd0, 1'b1,
          '{1'b1, 32'h8000_0000, 64'd0, 5'd2, 1'b1}},
        '{REQ_INSERT, 32'd0, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{REQ_INSERT, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{REQ_LOOKUP, 32'd0, 64'd0, 1'b0, '0},
        '{REQ_ABSENT, 32'd0, 64'd0, 1'b1, '{1'b0, 32'd0, 64'd0, 5'd4, 1'b1}},
        '{REQ_UNUSED_LO, 32'd123, 64'hDEAD_BEEF_0000_0001, 1'b1,
          '{1'b0, 32'd0, 64'd0, 5'd4, 1'b1}},
        '{REQ_DUMP,   32'd0, 64'd0, 1'b0, '0},
        '{REQ_INSERT, -32'sd3, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{REQ_INSERT, 32'd100, 64'h1111_2222_3333_4444, 1'b0, '0},
        '{REQ_INSERT, -32'sd100, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, '0},
        '{REQ_INSERT, 32'd1, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{REQ_INSERT, 32'd2, 64'h0000_0000_0000_0001, 1'b0, '0},
        '{REQ_INSERT, 32'd50, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{REQ_INSERT, -32'sd50, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{REQ_INSERT, 32'd0, 64'hC3C3_C3C3_3C3C_3C3C, 1'b0, '0},
        '{REQ_INSERT, 32'h7FFF_FFFE, 64'h0000_FFFF_0000_FFFF, 1'b0, '0},
        '{REQ_INSERT, 32'h8000_0001, 64'hFFFF_0000_FFFF_0000, 1'b0, '0},
        '{REQ_INSERT, 32'd9, 64'h9999_9999_9999_9999, 1'b0, '0},
        '{REQ_INSERT, -32'sd9, 64'h6666_6666_6666_6666, 1'b0, '0},
        '{REQ_INSERT, 32'd42, 64'h4242_4242_4242_4242, 1'b1,
          '{1'b0, 32'd42, 64'h4242_4242_4242_4242, 5'd16, 1'b1}},
        '{REQ_DUMP,   32'd0, 64'd0, 1'b0, '0},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 64'd0, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table_core #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Mirror of the table contents and the beats still owed by the block
    logic [KEY_W-1:0] mirror_keys [TABLE_DEPTH];
    logic [PAY_W-1:0] mirror_payloads [TABLE_DEPTH];
    int               mirror_count = 0;
    table_result_t    expected_results [$];

    int mismatch_count = 0;
    bit quiet_tail     = 1'b0;
    bit hold_rsp_long  = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue one expected beat; entries reflects the count after the request
    function automatic void push_result(input logic ok, input logic [KEY_W-1:0] k,
                                        input logic [PAY_W-1:0] p, input logic last);
        expected_results.push_back('{ok, k, p, ENT_W'(mirror_count), last});
    endfunction

    // Apply one request to the mirror and queue the beats it produces
    function automatic void predict_request(input req_t rq, input logic [KEY_W-1:0] k,
                                            input logic [PAY_W-1:0] p);
        int match;
        int pos;
        logic [PAY_W-1:0] taken;
        match = mirror_count;
        for (int i = mirror_count - 1; i >= 0; i--)
        begin
            if (mirror_keys[i] == k)
                match = i;
        end
        case (rq)
            REQ_INSERT:
            begin
                if (mirror_count >= TABLE_DEPTH)
                begin
                    push_result(1'b0, k, p, 1'b1);
                end
                else
                begin
                    // new entry goes ahead of the first key that is not smaller
                    pos = 0;
                    while (pos < mirror_count && $signed(mirror_keys[pos]) < $signed(k))
                        pos++;
                    for (int i = mirror_count; i > pos; i--)
                    begin
                        mirror_keys[i]     = mirror_keys[i-1];
                        mirror_payloads[i] = mirror_payloads[i-1];
                    end
                    mirror_keys[pos]     = k;
                    mirror_payloads[pos] = p;
                    mirror_count++;
                    push_result(1'b1, k, p, 1'b1);
                end
            end
            REQ_REMOVE:
            begin
                if (match >= mirror_count)
                begin
                    push_result(1'b0, k, '0, 1'b1);
                end
                else
                begin
                    taken = mirror_payloads[match];
                    for (int i = match; i + 1 < mirror_count; i++)
                    begin
                        mirror_keys[i]     = mirror_keys[i+1];
                        mirror_payloads[i] = mirror_payloads[i+1];
                    end
                    mirror_count--;
                    push_result(1'b1, k, taken, 1'b1);
                end
            end
            REQ_LOOKUP:
            begin
                if (match >= mirror_count)
                    push_result(1'b0, k, '0, 1'b1);
                else
                    push_result(1'b1, k, mirror_payloads[match], 1'b1);
            end
            REQ_ABSENT:
            begin
                push_result(match >= mirror_count, k, '0, 1'b1);
            end
            REQ_DUMP:
            begin
                if (mirror_count == 0)
                    push_result(1'b0, '0, '0, 1'b1);
                for (int i = 0; i < mirror_count; i++)
                    push_result(1'b1, mirror_keys[i], mirror_payloads[i],
                                i + 1 == mirror_count);
            end
            default:
            begin
                push_result(1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one request beat, with an occasional idle burst ahead of it
    task automatic put_request(input req_t rq, input logic [KEY_W-1:0] k,
                               input logic [PAY_W-1:0] p, input logic typed,
                               input table_result_t want);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rq;
        req_ch.key      <= k;
        req_ch.payload  <= p;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_request(rq, k, p);
        // typed rows are single-beat; their own beat replaces the mirror's
        if (typed)
        begin
            void'(expected_results.pop_back());
            expected_results.push_back(want);
        end
    endtask

    task automatic report_field(input string name, input logic [PAY_W-1:0] exp_val,
                                input logic [PAY_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Result monitor: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        table_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual key %h payload %h",
                         $time, rsp_ch.out_key, rsp_ch.out_payload);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("ok", PAY_W'(want.ok), PAY_W'(rsp_ch.ok));
                report_field("out_key", PAY_W'(want.key),
                             PAY_W'($unsigned(rsp_ch.out_key)));
                report_field("out_payload", want.payload, rsp_ch.out_payload);
                report_field("entries", PAY_W'(want.entries), PAY_W'(rsp_ch.entries));
                report_field("last", PAY_W'(want.last), PAY_W'(rsp_ch.last));
            end
        end
    end

    // Result ready: random stall bursts, plus one long hold-off on request
    initial
    begin : rsp_ready_driver
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp_long)
            begin
                hold_rsp_long = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left   = $urandom_range(1, 7) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Request stream: directed rows, then random fill and drain phases
    initial
    begin : request_driver
        req_t             rq;
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        int               roll;
        int               ins_share;
        int               rem_share;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key      = '0;
        req_ch.payload  = '0;
        rst_n           = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIR_ROWS[i])
            put_request(DIR_ROWS[i].rq, DIR_ROWS[i].key, DIR_ROWS[i].payload,
                        DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            // alternate insert-heavy and remove-heavy phases
            ins_share = ((n / 40) % 2 == 0) ? 50 : 20;
            rem_share = ((n / 40) % 2 == 0) ? 15 : 45;
            roll = $urandom_range(0, 99);
            if (roll < ins_share)
                rq = REQ_INSERT;
            else if (roll < ins_share + rem_share)
                rq = REQ_REMOVE;
            else if (roll < ins_share + rem_share + 12)
                rq = REQ_LOOKUP;
            else if (roll < ins_share + rem_share + 20)
                rq = REQ_ABSENT;
            else if (roll < ins_share + rem_share + 30)
                rq = REQ_DUMP;
            else
                rq = req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));

            // matching requests often target a key that is held
            roll = $urandom_range(0, 31);
            if (rq != REQ_INSERT && mirror_count > 0 && $urandom_range(0, 1) == 1)
                k = mirror_keys[$urandom_range(0, mirror_count - 1)];
            else if (roll == 0)
                k = 32'h8000_0000;
            else if (roll == 1)
                k = 32'h7FFF_FFFF;
            else if (roll < 26)
                k = KEY_W'(roll - 14);
            else
                k = $urandom();
            p = {$urandom(), $urandom()};

            put_request(rq, k, p, 1'b0, '0);

            if (n == 150)
                hold_rsp_long = 1'b1;
            if (n == 300)
            begin
                // sender quiet until the block has answered everything
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sorted_key_table_core.f @@
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_if.sv
hdl/skt_cell.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table_core.sv
bench/tb_top.sv
